>>> rtl/awcs_pkg.sv
// Shared types, codes and reset values for the adaptive write cache sizer.
`default_nettype none

package awcs_pkg;

  localparam int SIZE_WIDTH_DEF = 32;

  localparam int PCT_W  = 10;
  localparam int SIZE_W = 31;
  localparam int GRAN_W = 21;
  localparam int STEP_W = 32;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_PERCENT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CACHE_MIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_CACHE_MAX = 2'd2;
  localparam logic [IDX_W-1:0] REG_GRANULE   = 2'd3;

  localparam logic [PCT_W-1:0]  PERCENT_RST   = 10'd10;
  localparam logic [SIZE_W-1:0] CACHE_MIN_RST = 31'd4096;
  localparam logic [SIZE_W-1:0] CACHE_MAX_RST = 31'd1048576;
  localparam logic [GRAN_W-1:0] GRANULE_RST   = 21'd4096;
  localparam logic [SIZE_W-1:0] CACHE_SIZE_RST = 31'd4096;

  localparam logic [7:0] WRITE_SCALE = 8'd100;

  localparam logic [KIND_W-1:0] KIND_SAME   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GROW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHRINK = 2'd2;

  typedef enum logic [2:0] {
    DIR_HOLD = 3'b001,
    DIR_UP   = 3'b010,
    DIR_DOWN = 3'b100
  } dir_t;

  typedef struct packed {
    logic [PCT_W-1:0]  min_write_percent;
    logic [SIZE_W-1:0] cache_min;
    logic [SIZE_W-1:0] cache_max;
    logic [GRAN_W-1:0] cache_granule;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/awcs_update.sv
// Step and cache size update for one flush decision.
`default_nettype none

module awcs_update #(
  parameter int SIZE_WIDTH = awcs_pkg::SIZE_WIDTH_DEF
) (
  input  awcs_pkg::cfg_t                        cfg,
  input  awcs_pkg::dir_t                        dir,
  input  logic [awcs_pkg::SIZE_W-1:0]           size,
  input  logic signed [awcs_pkg::STEP_W-1:0]    step,
  output logic [awcs_pkg::SIZE_W-1:0]           size_next,
  output logic signed [awcs_pkg::STEP_W-1:0]    step_next,
  output logic [awcs_pkg::KIND_W-1:0]           kind
);
  import awcs_pkg::*;

  localparam int PROD_W = STEP_W + GRAN_W + 1;
  localparam int BW = (SIZE_WIDTH > PROD_W + 2) ? SIZE_WIDTH : PROD_W + 2;
  localparam logic signed [BW-1:0] SZ_HI =
    {{(BW-SIZE_WIDTH+1){1'b0}}, {(SIZE_WIDTH-1){1'b1}}};
  localparam logic signed [BW-1:0] SZ_LO = ~SZ_HI;
  localparam logic signed [STEP_W:0] STEP_HI = (STEP_W+1)'(2**(STEP_W-1) - 1);
  localparam logic signed [STEP_W:0] STEP_LO = ~STEP_HI;

  logic signed [STEP_W:0]   step_ext;
  logic signed [STEP_W:0]   step_neg;
  logic signed [STEP_W:0]   step_adj;
  logic signed [STEP_W-1:0] step_s;
  logic signed [STEP_W:0]   step_s_ext;
  logic signed [STEP_W:0]   step_inc;
  logic signed [STEP_W:0]   step_inc_neg;
  logic signed [PROD_W-1:0] prod;
  logic signed [BW-1:0]     sum;
  logic signed [BW-1:0]     sum_sat;
  logic signed [BW-1:0]     max_ext;
  logic signed [BW-1:0]     min_ext;
  logic                     moving;

  always_comb begin
    step_ext     = {step[STEP_W-1], step};
    step_neg     = -step_ext;
    step_adj     = step_ext;
    moving       = 1'b0;
    max_ext      = BW'(signed'({1'b0, cfg.cache_max}));
    min_ext      = BW'(signed'({1'b0, cfg.cache_min}));
    case (dir)
      DIR_UP: begin
        if (size < cfg.cache_max) begin
          moving = 1'b1;
          if (step > 0) begin
            step_adj = step_ext <<< 1;
          end else if (step < 0) begin
            step_adj = step_neg >>> 1;
          end else begin
            step_adj = (STEP_W+1)'(1);
          end
        end
      end
      DIR_DOWN: begin
        if (size > cfg.cache_min) begin
          moving = 1'b1;
          if (step < 0) begin
            step_adj = step_ext <<< 1;
          end else if (step > 0) begin
            step_adj = -(step_ext >>> 1);
          end else begin
            step_adj = -(STEP_W+1)'(1);
          end
        end
      end
      default: begin
        moving = 1'b0;
      end
    endcase

    if (step_adj > STEP_HI) begin
      step_s = STEP_HI[STEP_W-1:0];
    end else if (step_adj < STEP_LO) begin
      step_s = STEP_LO[STEP_W-1:0];
    end else begin
      step_s = step_adj[STEP_W-1:0];
    end
    step_s_ext   = {step_s[STEP_W-1], step_s};
    step_inc     = step_s_ext + (STEP_W+1)'(1);
    step_inc_neg = -step_inc;

    prod = PROD_W'(step_s) * PROD_W'(signed'({1'b0, cfg.cache_granule}));
    sum  = BW'(signed'({1'b0, size})) + BW'(prod);
    if (sum > SZ_HI) begin
      sum_sat = SZ_HI;
    end else if (sum < SZ_LO) begin
      sum_sat = SZ_LO;
    end else begin
      sum_sat = sum;
    end

    size_next = size;
    step_next = step;
    if (moving) begin
      size_next = sum_sat[SIZE_W-1:0];
      step_next = step_s;
      if (dir == DIR_UP && sum_sat > max_ext) begin
        size_next = cfg.cache_max;
        if (step_s == 0) begin
          step_next = '0;
        end else begin
          step_next = (step_s - STEP_W'(1)) >>> 1;
        end
      end else if (dir == DIR_DOWN && sum_sat < min_ext) begin
        size_next = cfg.cache_min;
        step_next = -(STEP_W'(step_inc_neg >>> 1));
      end
    end

    if (size_next > size) begin
      kind = KIND_GROW;
    end else if (size_next < size) begin
      kind = KIND_SHRINK;
    end else begin
      kind = KIND_SAME;
    end
  end

endmodule

`default_nettype wire

>>> rtl/adaptive_write_cache_sizer_unit.sv
// Top level of the adaptive write cache sizer: registers, pipeline and handshakes.
// An accepted word passes through the input, waste test and state update registers in turn.
// Throughput: one word per cycle while the receiver does not stall; the size and step
// update is a feedback loop through one 32x22 multiply, add, saturate and clamp.
// Reset (rst, synchronous): empties the pipeline, sets size to 4096, step to 0
// and all configuration registers to their defaults.
`default_nettype none

module adaptive_write_cache_sizer_unit #(
  parameter int SIZE_WIDTH = awcs_pkg::SIZE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [awcs_pkg::IDX_W-1:0]          cfg_index,
  input  logic [awcs_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [awcs_pkg::SIZE_W-1:0]         waste_bytes,
  input  logic [awcs_pkg::SIZE_W-1:0]         flushed_bytes,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [awcs_pkg::SIZE_W-1:0]         cache_size,
  output logic signed [awcs_pkg::STEP_W-1:0]  step_count,
  output logic [awcs_pkg::KIND_W-1:0]         change_kind
);
  import awcs_pkg::*;

  localparam int LHS_W = PCT_W + SIZE_W;

  cfg_t                     cfg;
  logic                     v1;
  logic                     v2;
  logic [SIZE_W-1:0]        waste_q;
  logic [SIZE_W-1:0]        flushed_q;
  dir_t                     dir_q;
  dir_t                     dir_next;
  logic [LHS_W-1:0]         lhs;
  logic [LHS_W-1:0]         rhs;
  logic                     ready_out;
  logic                     ready2;
  logic                     ready1;
  logic [SIZE_W-1:0]        size_reg;
  logic signed [STEP_W-1:0] step_reg;
  logic [SIZE_W-1:0]        size_next;
  logic signed [STEP_W-1:0] step_next;
  logic [KIND_W-1:0]        kind_next;
  logic [KIND_W-1:0]        kind_reg;

  assign ready_out = !out_valid || !out_stall;
  assign ready2    = !v2 || ready_out;
  assign ready1    = !v1 || ready2;
  assign in_stall  = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_write_percent <= PERCENT_RST;
      cfg.cache_min         <= CACHE_MIN_RST;
      cfg.cache_max         <= CACHE_MAX_RST;
      cfg.cache_granule     <= GRANULE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PERCENT:   cfg.min_write_percent <= cfg_data[PCT_W-1:0];
        REG_CACHE_MIN: cfg.cache_min         <= cfg_data;
        REG_CACHE_MAX: cfg.cache_max         <= cfg_data;
        REG_GRANULE:   cfg.cache_granule     <= cfg_data[GRAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage 1: input word
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      waste_q   <= waste_bytes;
      flushed_q <= flushed_bytes;
    end
  end

  // stage 2: waste test
  always_comb begin
    lhs = LHS_W'(cfg.min_write_percent) * LHS_W'(waste_q);
    rhs = LHS_W'(WRITE_SCALE) * LHS_W'(flushed_q);
    if (lhs < rhs) begin
      dir_next = DIR_UP;
    end else if (waste_q != '0) begin
      dir_next = DIR_DOWN;
    end else begin
      dir_next = DIR_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      dir_q <= dir_next;
    end
  end

  // stage 3: state update and result
  awcs_update #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_update (
    .cfg       (cfg),
    .dir       (dir_q),
    .size      (size_reg),
    .step      (step_reg),
    .size_next (size_next),
    .step_next (step_next),
    .kind      (kind_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      size_reg  <= CACHE_SIZE_RST;
      step_reg  <= '0;
    end else if (ready_out) begin
      out_valid <= v2;
      if (v2) begin
        size_reg <= size_next;
        step_reg <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && v2) begin
      kind_reg <= kind_next;
    end
  end

  assign cache_size  = size_reg;
  assign step_count  = step_reg;
  assign change_kind = kind_reg;

`ifndef SYNTH
  a_hold_same: assert property (@(posedge clk) disable iff (rst)
    (v2 && dir_q == DIR_HOLD && ready_out) |=> (out_valid && change_kind == KIND_SAME))
    else $error("hold decision changed the cache size");

  a_state_frozen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(size_reg) && $stable(step_reg)))
    else $error("state moved while result waits");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && out_valid && out_stall) |-> in_stall)
    else $error("input taken while pipeline full");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && !v1 && !v2 && size_reg == CACHE_SIZE_RST && step_reg == 0))
    else $error("reset state wrong");
`endif

endmodule

`default_nettype wire

>>> tb/tb_adaptive_write_cache_sizer_unit.sv
// Self-checking testbench for the adaptive write cache sizer: directed and random flush traffic.
`timescale 1ns / 100ps

module tb_adaptive_write_cache_sizer_unit;
  import awcs_pkg::*;

  localparam int SIZE_WIDTH = SIZE_WIDTH_DEF;
  localparam longint STEP_HI = 2147483647;
  localparam longint STEP_LO = -STEP_HI - 1;
  localparam longint SIZE_HI = (longint'(1) << (SIZE_WIDTH - 1)) - 1;
  localparam longint SIZE_LO = -SIZE_HI - 1;
  localparam longint BYTES_LIM = 2147483647;
  localparam logic [SIZE_W-1:0] BYTES_MAX = '1;

  typedef struct {
    logic [SIZE_W-1:0] size;
    logic signed [STEP_W-1:0] step;
    logic [KIND_W-1:0] kind;
  } sizer_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SIZE_W-1:0] waste_bytes = '0;
  logic [SIZE_W-1:0] flushed_bytes = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SIZE_W-1:0] cache_size;
  logic signed [STEP_W-1:0] step_count;
  logic [KIND_W-1:0] change_kind;

  adaptive_write_cache_sizer_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .waste_bytes(waste_bytes),
    .flushed_bytes(flushed_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cache_size(cache_size),
    .step_count(step_count),
    .change_kind(change_kind)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracked configuration and sizer state
  logic [PCT_W-1:0] cfg_percent = PERCENT_RST;
  logic [SIZE_W-1:0] cfg_min = CACHE_MIN_RST;
  logic [SIZE_W-1:0] cfg_max = CACHE_MAX_RST;
  logic [GRAN_W-1:0] cfg_granule = GRANULE_RST;
  logic [SIZE_W-1:0] cur_size = CACHE_SIZE_RST;
  int cur_step = 0;

  sizer_word_t pending_sizes[$];
  sizer_word_t head;
  int error_count = 0;
  int burst_left = 0;
  bit eager_sender = 1'b0;
  int stall_tick = 0;
  int stall_mode = 0;

  function automatic longint clip_step(input longint v);
    if (v > STEP_HI) return STEP_HI;
    if (v < STEP_LO) return STEP_LO;
    return v;
  endfunction

  function automatic longint clip_size(input longint v);
    if (v > SIZE_HI) return SIZE_HI;
    if (v < SIZE_LO) return SIZE_LO;
    return v;
  endfunction

  function automatic sizer_word_t adjust_cache(input logic [SIZE_W-1:0] waste,
                                               input logic [SIZE_W-1:0] flushed);
    longint old_sz, sz, st, gran;
    sizer_word_t res;
    old_sz = longint'(cur_size);
    sz = old_sz;
    st = longint'(cur_step);
    gran = longint'(cfg_granule);
    if (longint'(cfg_percent) * longint'(waste) < 100 * longint'(flushed)) begin
      if (sz < longint'(cfg_max)) begin
        if (st > 0) st = clip_step(st * 2);
        else if (st < 0) st = st / -2;
        else st = 1;
        sz = clip_size(sz + st * gran);
        if (sz > longint'(cfg_max)) begin
          sz = longint'(cfg_max);
          st = (st - 1) / 2;
        end
      end
    end else if (waste != 0) begin
      if (sz > longint'(cfg_min)) begin
        if (st < 0) st = clip_step(st * 2);
        else if (st > 0) st = st / -2;
        else st = -1;
        sz = clip_size(sz + st * gran);
        if (sz < longint'(cfg_min)) begin
          sz = longint'(cfg_min);
          st = (st + 1) / 2;
        end
      end
    end
    st = clip_step(st);
    if (sz < 0) sz = 0;
    cur_size = sz[SIZE_W-1:0];
    cur_step = int'(st);
    res.size = cur_size;
    res.step = cur_step;
    if (longint'(cur_size) > old_sz) res.kind = KIND_GROW;
    else if (longint'(cur_size) < old_sz) res.kind = KIND_SHRINK;
    else res.kind = KIND_SAME;
    return res;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_span();
    return SIZE_W'($urandom >> $urandom_range(1, 31));
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ((stall_tick % 7) < 3);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_sizes.size() == 0) begin
        flag_error($sformatf("unexpected word, size %0d", cache_size));
      end else begin
        head = pending_sizes.pop_front();
        if (cache_size !== head.size)
          flag_error($sformatf("cache_size %0d, want %0d", cache_size, head.size));
        if (step_count !== head.step)
          flag_error($sformatf("step_count %0d, want %0d", step_count, head.step));
        if (change_kind !== head.kind)
          flag_error($sformatf("change_kind %0d, want %0d", change_kind, head.kind));
      end
    end
  end

  task automatic send_word(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (eager_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    waste_bytes <= w;
    flushed_bytes <= f;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_sizes.push_back(adjust_cache(w, f));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_PERCENT: cfg_percent = val[PCT_W-1:0];
      REG_CACHE_MIN: cfg_min = val;
      REG_CACHE_MAX: cfg_max = val;
      REG_GRANULE: cfg_granule = val[GRAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_config(input logic [SIZE_W-1:0] pct, mn, mx, gr);
    wait_drained();
    write_reg(REG_PERCENT, pct);
    write_reg(REG_CACHE_MIN, mn);
    write_reg(REG_CACHE_MAX, mx);
    write_reg(REG_GRANULE, gr);
    cfg_write <= 1'b0;
  endtask

  task automatic test_defaults();
    send_word(0, 1);
    send_word(0, 100);
    send_word(1, 1);
    send_word(10, 1);          // exactly at threshold: large waste
    send_word(0, 0);           // nothing to do
    send_word(BYTES_MAX, BYTES_MAX);
    send_word(BYTES_MAX, 0);
    send_word(1, 0);
    repeat (3) send_word(BYTES_MAX, 0);
    send_word(100, 9);
  endtask

  task automatic test_clamps();
    program_config(100, 8192, 65536, 4096);
    repeat (6) send_word(1, 2);
    send_word(1, 1);
    repeat (6) send_word(2, 1);
  endtask

  task automatic test_register_extremes();
    // min above max, zero percent, widest granule
    program_config(0, BYTES_MAX, 0, 31'h1F_FFFF);
    send_word(BYTES_MAX, 0);
    send_word(0, 1);
    program_config(1023, 0, BYTES_MAX, 31'h10_0000);
    repeat (12) send_word(0, BYTES_MAX);
    send_word(1, 10);
    repeat (7) send_word(BYTES_MAX, 0);
  endtask

  task automatic test_step_saturation();
    program_config(10, 0, BYTES_MAX, 1);
    repeat (2) send_word(BYTES_MAX, 0);
    program_config(10, 0, BYTES_MAX, 0);
    repeat (34) send_word(0, 1);
    repeat (36) send_word(1, 0);
  endtask

  task automatic test_random_traffic();
    int phase, n, run_left, run_class, sel;
    longint lim;
    logic [SIZE_W-1:0] w, f, pct, mn, mx, gr;
    run_left = 0;
    run_class = 0;
    for (phase = 0; phase < 11; phase++) begin
      pct = SIZE_W'($urandom);
      sel = $urandom_range(0, 5);
      case (sel)
        0: pct[PCT_W-1:0] = '0;
        1: pct[PCT_W-1:0] = 1;
        2: pct[PCT_W-1:0] = '1;
        default: pct[PCT_W-1:0] = PCT_W'($urandom_range(1, 1000));
      endcase
      sel = $urandom_range(0, 4);
      case (sel)
        0: begin
          mn = '0;
          mx = BYTES_MAX;
        end
        1: begin
          mx = SIZE_W'($urandom_range(0, 1 << 20));
          mn = mx + SIZE_W'($urandom_range(1, 1 << 16));
        end
        2: begin
          mn = SIZE_W'($urandom);
          mx = SIZE_W'($urandom);
        end
        3: begin
          mn = SIZE_W'($urandom_range(0, 1 << 16));
          mx = mn;
        end
        default: begin
          mn = SIZE_W'($urandom_range(0, 1 << 20));
          mx = mn + SIZE_W'($urandom_range(0, 1 << 24));
        end
      endcase
      gr = SIZE_W'($urandom);
      sel = $urandom_range(0, 5);
      case (sel)
        0: gr[GRAN_W-1:0] = '0;
        1: gr[GRAN_W-1:0] = 1;
        2: gr[GRAN_W-1:0] = '1;
        3: gr[GRAN_W-1:0] = 4096;
        4: gr[GRAN_W-1:0] = GRAN_W'($urandom_range(1, 64));
        default: ;
      endcase
      program_config(pct, mn, mx, gr);
      eager_sender = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 150; n++) begin
        if (phase % 3 == 1 && n == 75) wait_drained();
        if (run_left == 0) begin
          run_left = $urandom_range(1, 10);
          sel = $urandom_range(0, 99);
          run_class = sel < 40 ? 0 : sel < 70 ? 1 : sel < 80 ? 2 : sel < 85 ? 3 : 4;
        end
        run_left--;
        case (run_class)
          0: begin  // small waste: grow
            f = rand_span();
            if (f == 0) f = 1;
            lim = (cfg_percent == 0) ? BYTES_LIM
                : (100 * longint'(f) - 1) / longint'(cfg_percent);
            if (lim > BYTES_LIM) lim = BYTES_LIM;
            w = ($urandom_range(0, 3) == 0) ? SIZE_W'(lim)
                : SIZE_W'($urandom_range(0, 32'(lim)));
          end
          1: begin  // large waste: shrink
            w = rand_span();
            if (w == 0) w = 1;
            lim = longint'(cfg_percent) * longint'(w) / 100;
            if (lim > BYTES_LIM) lim = BYTES_LIM;
            f = ($urandom_range(0, 3) == 0) ? SIZE_W'(lim)
                : SIZE_W'($urandom_range(0, 32'(lim)));
          end
          2: begin
            w = '0;
            f = $urandom_range(0, 1) ? rand_span() : '0;
          end
          3: begin  // exact threshold
            lim = $urandom_range(0, 1 << 20);
            w = SIZE_W'(100 * lim);
            f = SIZE_W'(longint'(cfg_percent) * lim);
          end
          default: begin
            w = SIZE_W'($urandom);
            f = SIZE_W'($urandom);
          end
        endcase
        send_word(w, f);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_clamps();
    test_register_extremes();
    test_step_saturation();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
